// ===== src/hslp_pkg.sv =====
// shared types, codes and helpers for the hex sample list parser
// no dependencies; used by the interfaces, the parser core and the top level

package hslp_pkg;

  // default sample limit and reset value of the samples_expected configuration register
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd1008;

  // request field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;

  // result field widths
  localparam int STATUS_W = 3;
  localparam int VALUE_W = 8;
  localparam int INDEX_W = 12;

  // request modes
  localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EOF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // status codes of a result
  localparam logic [STATUS_W-1:0] ST_SAMPLE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PREFIX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIGIT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SEP    = 3'd4;

  // characters of the block syntax
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

  // running extremes with no sample seen
  localparam logic [VALUE_W-1:0] MIN_INIT = 8'hFF;
  localparam logic [VALUE_W-1:0] MAX_INIT = 8'h00;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  sample_value;
    logic [INDEX_W-1:0]  sample_index;
    logic [VALUE_W-1:0]  min_value;
    logic [VALUE_W-1:0]  max_value;
    logic                final_res;
  } res_t;

  // hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== src/hslp_intf.sv =====
// valid/ready channel interfaces: character requests, results and configuration
// depends on hslp_pkg for field widths

interface hslp_req_if;
  import hslp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, mode, char_byte, input ready);
  modport sink   (input valid, mode, char_byte, output ready);
endinterface

interface hslp_res_if;
  import hslp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  sample_value;
  logic [INDEX_W-1:0]  sample_index;
  logic [VALUE_W-1:0]  min_value;
  logic [VALUE_W-1:0]  max_value;
  logic                final_res;

  modport source (output valid, status, sample_value, sample_index, min_value, max_value,
                  final_res, input ready);
  modport sink   (input valid, status, sample_value, sample_index, min_value, max_value,
                  final_res, output ready);
endinterface

interface hslp_cfg_if;
  import hslp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] samples_expected;

  modport source (output valid, samples_expected, input ready);
  modport sink   (input valid, samples_expected, output ready);
endinterface

// ===== src/hex_sample_list_parser_core.sv =====
// A result is registered and presented in the cycle after the request that causes it.
// Throughput: one character request per cycle; each request is a single state
// update in the parser. A result left waiting in the result register holds back
// further requests until it is taken.
// Reset: parser idle, count 0, min 255, max 0, samples_expected 1008, no result.
// depends on hslp_pkg, hslp_intf and hslp_parser

module hex_sample_list_parser_core #(
  parameter int MaxSamples = hslp_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hslp_req_if.sink    req_i,
  hslp_cfg_if.sink    cfg_i,
  hslp_res_if.source  res_o
);
  import hslp_pkg::*;

  logic [CFG_W-1:0] samples_expected_q;
  logic             req_fire;
  logic             out_free;
  logic             res_vld;
  res_t             res;
  logic             res_vld_q;
  res_t             res_q;

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_expected_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      samples_expected_q <= cfg_i.samples_expected;
    end
  end

  // request handshake: take a request whenever the result register can move on
  assign out_free    = !res_vld_q || res_o.ready;
  assign req_i.ready = out_free;
  assign req_fire    = req_i.valid && out_free;

  hslp_parser #(
    .MaxSamples (MaxSamples)
  ) u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (req_fire),
    .mode_i             (req_i.mode),
    .char_byte_i        (req_i.char_byte),
    .samples_expected_i (samples_expected_q),
    .res_vld_o          (res_vld),
    .res_o              (res)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_free) begin
      res_vld_q <= req_fire && res_vld;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (out_free && req_fire && res_vld) begin
      res_q <= res;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.status       = res_q.status;
  assign res_o.sample_value = res_q.sample_value;
  assign res_o.sample_index = res_q.sample_index;
  assign res_o.min_value    = res_q.min_value;
  assign res_o.max_value    = res_q.max_value;
  assign res_o.final_res    = res_q.final_res;

  // a closing result never carries the sample status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.final_res) |-> (res_q.status != ST_SAMPLE))
    else $error("closing result with sample status");

  // a taken result with nothing new behind it leaves the register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_o.ready && !(req_fire && res_vld)) |=> !res_vld_q)
    else $error("result repeated after being taken");

  // a new result is captured whenever a request produces one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && res_vld) |=> res_vld_q)
    else $error("result lost");

endmodule

// ===== src/hslp_parser.sv =====
// parser state machine: prefix check, hex digit pairs, separators, min/max tracking
// depends on hslp_pkg for codes, the result struct and the hex decoder

module hslp_parser #(
  parameter int MaxSamples = hslp_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [hslp_pkg::MODE_W-1:0]  mode_i,
  input  logic [hslp_pkg::CHAR_W-1:0]  char_byte_i,
  input  logic [hslp_pkg::CFG_W-1:0]   samples_expected_i,
  output logic                         res_vld_o,
  output hslp_pkg::res_t               res_o
);
  import hslp_pkg::*;

  localparam int CntW = $clog2(MaxSamples + 1);
  localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HASH, PH_LETTER, PH_HI, PH_LO, PH_SEP
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [3:0]          high_nibble_q, high_nibble_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [VALUE_W-1:0]  min_q, min_d;
  logic [VALUE_W-1:0]  max_q, max_d;

  logic                eof;
  logic [4:0]          digit;
  logic                digit_ok;
  logic [VALUE_W-1:0]  value;
  logic [CmpW-1:0]     se_ext;
  logic [CmpW-1:0]     limit;
  logic                last_due;

  // decoded character and clamped sample limit
  assign eof      = (mode_i == MODE_EOF);
  assign digit    = hex_decode(char_byte_i);
  assign digit_ok = digit[4] && !eof;
  assign value    = {high_nibble_q, digit[3:0]};
  assign se_ext   = CmpW'(samples_expected_i);

  always_comb begin
    if (se_ext == '0) begin
      limit = CmpW'(1);
    end else if (se_ext > CmpW'(MaxSamples)) begin
      limit = CmpW'(MaxSamples);
    end else begin
      limit = se_ext;
    end
  end

  assign last_due = (CmpW'(count_q) >= limit);

  // next state and result for one request
  always_comb begin
    phase_d       = phase_q;
    high_nibble_d = high_nibble_q;
    count_d       = count_q;
    min_d         = min_q;
    max_d         = max_q;
    res_vld_o     = 1'b0;
    res_o         = '{status: ST_SAMPLE, sample_value: '0, sample_index: '0,
                      min_value: min_q, max_value: max_q, final_res: 1'b0};
    if (step_i) begin
      if (mode_i == MODE_START) begin
        phase_d       = PH_HASH;
        high_nibble_d = '0;
        count_d       = '0;
        min_d         = MIN_INIT;
        max_d         = MAX_INIT;
      end else if (mode_i != MODE_NONE && phase_q != PH_IDLE) begin
        unique case (phase_q)
          PH_HASH: begin
            if (eof || char_byte_i != CH_HASH) begin
              res_vld_o       = 1'b1;
              res_o.status    = ST_PREFIX;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              phase_d = PH_LETTER;
            end
          end
          PH_LETTER: begin
            if (eof || char_byte_i != CH_H) begin
              res_vld_o       = 1'b1;
              res_o.status    = ST_PREFIX;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              phase_d = PH_HI;
            end
          end
          PH_HI: begin
            if (!digit_ok) begin
              res_vld_o       = 1'b1;
              res_o.status    = ST_DIGIT;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              high_nibble_d = digit[3:0];
              phase_d       = PH_LO;
            end
          end
          PH_LO: begin
            if (!digit_ok) begin
              res_vld_o       = 1'b1;
              res_o.status    = ST_DIGIT;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              // sample complete: update extremes, emit it with its index
              if (value < min_q) min_d = value;
              if (value > max_q) max_d = value;
              if (count_q < CntW'(MaxSamples)) count_d = count_q + CntW'(1);
              phase_d            = PH_SEP;
              res_vld_o          = 1'b1;
              res_o.sample_value = value;
              res_o.sample_index = INDEX_W'(count_q);
              res_o.min_value    = (value < min_q) ? value : min_q;
              res_o.max_value    = (value > max_q) ? value : max_q;
            end
          end
          PH_SEP: begin
            if (last_due) begin
              res_vld_o       = 1'b1;
              res_o.status    = (eof || char_byte_i == CH_SEMI) ? ST_OK : ST_SEP;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else if (eof || char_byte_i != CH_COMMA) begin
              res_vld_o       = 1'b1;
              res_o.status    = ST_SEP;
              res_o.final_res = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              phase_d = PH_HI;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      high_nibble_q <= '0;
      count_q       <= '0;
      min_q         <= MIN_INIT;
      max_q         <= MAX_INIT;
    end else begin
      phase_q       <= phase_d;
      high_nibble_q <= high_nibble_d;
      count_q       <= count_d;
      min_q         <= min_d;
      max_q         <= max_d;
    end
  end

  // the sample count never passes MaxSamples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSamples))
    else $error("sample count above limit");

  // a sample result always sits inside the running extremes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && !res_o.final_res) |->
      (res_o.min_value <= res_o.sample_value && res_o.sample_value <= res_o.max_value))
    else $error("sample outside running min/max");

  // after a closing result the parser sits idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.final_res) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after closing result");

endmodule
